### hdl/vdp_pkg.sv
package vdp_pkg;

	// Default palette size.
	localparam int PALETTE_ENTRIES_DEF = 256;

	// Port addresses decoded by the block.
	localparam logic [15:0] PORT_READ_INDEX  = 16'h03C7;
	localparam logic [15:0] PORT_WRITE_INDEX = 16'h03C8;
	localparam logic [15:0] PORT_DATA        = 16'h03C9;

	// Access kinds.
	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	// Position in the red, green, blue sequence.
	localparam logic [1:0] STEP_RED   = 2'd0;
	localparam logic [1:0] STEP_GREEN = 2'd1;
	localparam logic [1:0] STEP_BLUE  = 2'd2;

	// One stored palette entry, 8 bits per color.
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// One bus access.
	typedef struct packed {
		logic        kind;
		logic [15:0] port;
		logic [7:0]  write_data;
	} item_t;

	// The outcome of one bus access.
	typedef struct packed {
		logic [5:0] read_data;
		logic       update_valid;
		logic [7:0] update_index;
		logic [7:0] update_red;
		logic [7:0] update_green;
		logic [7:0] update_blue;
		logic       bad_port;
	} result_t;

endpackage

### hdl/vdp_store.sv
module vdp_store import vdp_pkg::*; #(
	parameter int ENTRIES = PALETTE_ENTRIES_DEF,
	localparam int ADDR_W = $clog2(ENTRIES)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  rgb_t              wr_data,
	output rgb_t              rd_data
);

	// Palette memory, registered read.
	rgb_t mem [ENTRIES];
	rgb_t rd_raw_q;

	// One flag per entry; an entry never written reads as zero.
	logic [ENTRIES-1:0] valid_q;
	logic               rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_raw_q <= mem[rd_addr];
		end
	end

	// Entry flags are cleared at reset and set by the first write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_raw_q : '0;

endmodule

### hdl/vga_dac_palette_port_top.sv
// VGA-style DAC palette behind ports 0x3C7, 0x3C8 and 0x3C9. An item is taken at a
// rising edge with start high and busy low. Each item has a read phase for the
// registered read of the palette memory and a write phase to merge the new color
// component, write the entry back and update the pointer and red/green/blue step.
// Busy is high in the read phase of each accepted item; the next item can be
// taken in the write phase of the last. The result is registered in the write phase
// and shown for exactly one cycle with done high; the receiver cannot stall it. The
// palette clears at reset through one flag per entry, so no clearing pass is needed.
module vga_dac_palette_port_top import vdp_pkg::*; #(
	parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    done,
	output result_t result
);

	localparam int IDX_W = $clog2(PALETTE_ENTRIES);

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_READ  = 2'd1;
	localparam logic [1:0] PH_WRITE = 2'd2;

	// Table for loading the pointer: written byte modulo the palette size.
	typedef logic [IDX_W-1:0] wrap_lut_t [256];

	function automatic wrap_lut_t build_wrap_lut();
		wrap_lut_t lut;
		for (int i = 0; i < 256; i++) begin
			lut[i] = IDX_W'(i % PALETTE_ENTRIES);
		end
		return lut;
	endfunction

	localparam wrap_lut_t WRAP_LUT = build_wrap_lut();

	logic [1:0]       phase_q;
	logic [IDX_W-1:0] ptr_q;
	logic [1:0]       step_q;
	item_t            item_q;
	result_t          result_q;
	logic             done_q;

	logic             accept;
	logic [IDX_W-1:0] ptr_nxt;
	logic [IDX_W-1:0] ptr_inc;
	logic [1:0]       step_nxt;
	logic             wr_en;
	rgb_t             wr_data;
	rgb_t             entry;
	result_t          res_nxt;
	logic [7:0]       color;

	assign busy   = (phase_q == PH_READ);
	assign accept = start && !busy;
	assign done   = done_q;
	assign result = result_q;

	// Palette memory: read in the read phase, written in the write phase.
	vdp_store #(
		.ENTRIES (PALETTE_ENTRIES)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (phase_q == PH_READ),
		.rd_addr (ptr_q),
		.wr_en   (wr_en),
		.wr_addr (ptr_q),
		.wr_data (wr_data),
		.rd_data (entry)
	);

	assign ptr_inc = (ptr_q == IDX_W'(PALETTE_ENTRIES - 1)) ? '0 : ptr_q + IDX_W'(1);
	assign color   = {item_q.write_data[5:0], item_q.write_data[5:4]};

	// Decode the access and merge the component into the entry.
	always_comb begin
		ptr_nxt  = ptr_q;
		step_nxt = step_q;
		wr_en    = 1'b0;
		wr_data  = entry;
		res_nxt  = '0;
		if (item_q.kind == KIND_READ) begin
			if (item_q.port == PORT_WRITE_INDEX) begin
				res_nxt.read_data = '0;
			end else if (item_q.port == PORT_DATA) begin
				case (step_q)
					STEP_RED: begin
						res_nxt.read_data = entry.red[7:2];
						step_nxt = STEP_GREEN;
					end
					STEP_GREEN: begin
						res_nxt.read_data = entry.green[7:2];
						step_nxt = STEP_BLUE;
					end
					STEP_BLUE: begin
						res_nxt.read_data = entry.blue[7:2];
						step_nxt = STEP_RED;
						ptr_nxt  = ptr_inc;
					end
					default: begin
						res_nxt.bad_port = 1'b1;
					end
				endcase
			end else begin
				res_nxt.bad_port = 1'b1;
			end
		end else begin
			if (item_q.port inside {PORT_READ_INDEX, PORT_WRITE_INDEX}) begin
				ptr_nxt  = WRAP_LUT[item_q.write_data];
				step_nxt = STEP_RED;
			end else if (item_q.port == PORT_DATA) begin
				case (step_q)
					STEP_RED: begin
						wr_en         = 1'b1;
						wr_data.red   = color;
						step_nxt      = STEP_GREEN;
					end
					STEP_GREEN: begin
						wr_en         = 1'b1;
						wr_data.green = color;
						step_nxt      = STEP_BLUE;
					end
					STEP_BLUE: begin
						wr_en                = 1'b1;
						wr_data.blue         = color;
						step_nxt             = STEP_RED;
						ptr_nxt              = ptr_inc;
						res_nxt.update_valid = 1'b1;
						res_nxt.update_index = 8'(ptr_q);
						res_nxt.update_red   = entry.red;
						res_nxt.update_green = entry.green;
						res_nxt.update_blue  = color;
					end
					default: begin
						wr_en = 1'b0;
					end
				endcase
			end else begin
				res_nxt.bad_port = 1'b1;
			end
		end
		if (phase_q != PH_WRITE) begin
			wr_en = 1'b0;
		end
	end

	// Sequencer, pointer and step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			ptr_q   <= '0;
			step_q  <= STEP_RED;
			done_q  <= 1'b0;
		end else begin
			done_q <= (phase_q == PH_WRITE);
			case (phase_q)
				PH_IDLE: begin
					if (accept) begin
						phase_q <= PH_READ;
					end
				end
				PH_READ: begin
					phase_q <= PH_WRITE;
				end
				PH_WRITE: begin
					phase_q <= accept ? PH_READ : PH_IDLE;
					ptr_q   <= ptr_nxt;
					step_q  <= step_nxt;
				end
				default: begin
					phase_q <= PH_IDLE;
				end
			endcase
		end
	end

	// Item and result registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		if (phase_q == PH_WRITE) begin
			result_q <= res_nxt;
		end
	end

endmodule
